// File: hw/rtl/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
`default_nettype none

package mlr_pkg;

  // Default coordinate width of the endpoints and of pixel_x
  localparam int unsigned CoordBitsDefault = 10;

  // Window height register
  localparam int unsigned WinHeightBits = 11;
  localparam logic [WinHeightBits-1:0] WinHeightReset = 11'd512;

  // Request codes carried on req_type
  typedef enum logic [0:0] {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_type_e;

endpackage : mlr_pkg

`default_nettype wire

// File: hw/rtl/midpoint_line_rasterizer.sv
// Midpoint line rasterizer: y flip, octant setup and one result per request.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   in      | input     | in_valid_i/in_ready_o | req_type, start_x/y, end_x/y
//   out     | output    | out_valid_o/out_ready_i | pixel_x, pixel_y, pixel_valid, last_pixel
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (window_height)
//
// Each request yields exactly one result, registered through the input and result stages.
// One request is taken every cycle while no result stalls; the line stepper does one add and compare per pixel.
// The y flip happens in the input stage, setup or stepping in the result stage.
// Reset clears the valid flags, the active-line flag and sets window_height to 512.
// A stalled result holds both stages; the input stage still fills while empty.
`default_nettype none

module midpoint_line_rasterizer #(
  parameter int unsigned CoordBits = mlr_pkg::CoordBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mlr_pkg::WinHeightBits-1:0]  cfg_data_i,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [CoordBits-1:0]               start_x_i,
  input  logic [CoordBits-1:0]               start_y_i,
  input  logic [CoordBits-1:0]               end_x_i,
  input  logic [CoordBits-1:0]               end_y_i,
  // pixel channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [CoordBits-1:0]               pixel_x_o,
  output logic signed [CoordBits+1:0]        pixel_y_o,
  output logic                               pixel_valid_o,
  output logic                               last_pixel_o
);

  import mlr_pkg::*;

  // Position width: flipped y spans -(2^C - 1) .. 2^11 - 1
  localparam int unsigned MaxBits = (CoordBits > WinHeightBits) ? CoordBits : WinHeightBits;
  localparam int unsigned PosW    = MaxBits + 1;
  // Decision width: values stay within +/- 2^(C+1)
  localparam int unsigned DecW    = CoordBits + 3;
  localparam int unsigned OutYW   = CoordBits + 2;

  // Window height register
  logic [WinHeightBits-1:0] win_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_height_q <= WinHeightReset;
    end else if (cfg_valid_i) begin
      win_height_q <= cfg_data_i;
    end
  end

  // Handshake and stage control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic advance;
  logic in_fire;
  logic s2_fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s2_fire    = s1_valid_q && advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input stage: capture request, flip y to a bottom-left origin
  logic                   s1_step_q;
  logic [CoordBits-1:0]   s1_ax_q, s1_bx_q;
  logic signed [PosW-1:0] s1_ay_q, s1_by_q;
  logic signed [PosW-1:0] height_s;
  logic signed [PosW-1:0] ay_d, by_d;

  assign height_s = $signed(PosW'(win_height_q));
  assign ay_d     = height_s - $signed(PosW'(start_y_i));
  assign by_d     = height_s - $signed(PosW'(end_y_i));

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_step_q <= (req_type_i == REQ_STEP);
      s1_ax_q   <= start_x_i;
      s1_bx_q   <= end_x_i;
      s1_ay_q   <= ay_d;
      s1_by_q   <= by_d;
    end
  end

  // Line state
  logic                   line_active_q, line_active_d;
  logic signed [PosW-1:0] major_pos_q, major_pos_d;
  logic signed [PosW-1:0] minor_pos_q, minor_pos_d;
  logic signed [PosW-1:0] major_end_q, major_end_d;
  logic signed [DecW-1:0] decision_q, decision_d;
  logic signed [DecW-1:0] inc_straight_q, inc_straight_d;
  logic signed [DecW-1:0] inc_diagonal_q, inc_diagonal_d;
  logic                   axes_swapped_q, axes_swapped_d;
  logic                   minor_falls_q, minor_falls_d;

  // Setup for a start request
  logic signed [PosW-1:0] ax_s, bx_s;
  logic signed [PosW-1:0] dx_w, dy_w;
  logic [CoordBits-1:0]   dx, dy, dmaj, dmin;
  logic                   steep;
  logic signed [PosW-1:0] m0, n0, m1, n1;
  logic signed [PosW-1:0] om0, on0, om1, on1;
  logic signed [DecW-1:0] dmaj_s, dmin_s;

  assign ax_s  = $signed(PosW'(s1_ax_q));
  assign bx_s  = $signed(PosW'(s1_bx_q));
  assign dx_w  = (bx_s > ax_s) ? (bx_s - ax_s) : (ax_s - bx_s);
  assign dy_w  = (s1_by_q > s1_ay_q) ? (s1_by_q - s1_ay_q) : (s1_ay_q - s1_by_q);
  assign dx    = dx_w[CoordBits-1:0];
  assign dy    = dy_w[CoordBits-1:0];
  assign steep = dy > dx;

  // Pick the major axis, then order so the major coordinate rises
  always_comb begin
    if (steep) begin
      m0 = s1_ay_q; n0 = ax_s; m1 = s1_by_q; n1 = bx_s;
    end else begin
      m0 = ax_s; n0 = s1_ay_q; m1 = bx_s; n1 = s1_by_q;
    end
    if (m0 > m1) begin
      om0 = m1; on0 = n1; om1 = m0; on1 = n0;
    end else begin
      om0 = m0; on0 = n0; om1 = m1; on1 = n1;
    end
  end

  assign dmaj   = steep ? dy : dx;
  assign dmin   = steep ? dx : dy;
  assign dmaj_s = $signed(DecW'(dmaj));
  assign dmin_s = $signed(DecW'(dmin));

  // Step for a step request
  logic signed [PosW-1:0] major_next, minor_next;
  logic signed [DecW-1:0] decision_next;

  always_comb begin
    major_next = major_pos_q + PosW'(1);
    if (decision_q > 0) begin
      minor_next    = minor_falls_q ? (minor_pos_q - PosW'(1)) : (minor_pos_q + PosW'(1));
      decision_next = decision_q + inc_diagonal_q;
    end else begin
      minor_next    = minor_pos_q;
      decision_next = decision_q + inc_straight_q;
    end
  end

  // Next state and result
  logic [CoordBits-1:0]   pix_x_q, pix_x_d;
  logic signed [OutYW-1:0] pix_y_q, pix_y_d;
  logic                   pix_valid_q, pix_valid_d;
  logic                   last_q, last_d;
  logic signed [PosW-1:0] px, py;

  always_comb begin
    line_active_d  = line_active_q;
    major_pos_d    = major_pos_q;
    minor_pos_d    = minor_pos_q;
    major_end_d    = major_end_q;
    decision_d     = decision_q;
    inc_straight_d = inc_straight_q;
    inc_diagonal_d = inc_diagonal_q;
    axes_swapped_d = axes_swapped_q;
    minor_falls_d  = minor_falls_q;
    pix_valid_d    = 1'b0;
    if (!s1_step_q) begin
      axes_swapped_d = steep;
      minor_falls_d  = on1 < on0;
      major_pos_d    = om0;
      minor_pos_d    = on0;
      major_end_d    = om1;
      inc_straight_d = dmin_s <<< 1;
      inc_diagonal_d = (dmin_s - dmaj_s) <<< 1;
      decision_d     = (dmin_s <<< 1) - dmaj_s;
      pix_valid_d    = 1'b1;
    end else if (line_active_q) begin
      major_pos_d = major_next;
      minor_pos_d = minor_next;
      decision_d  = decision_next;
      pix_valid_d = 1'b1;
    end
    last_d = pix_valid_d && (major_pos_d == major_end_d);
    if (pix_valid_d) begin
      line_active_d = !last_d;
    end
    px = axes_swapped_d ? minor_pos_d : major_pos_d;
    py = axes_swapped_d ? major_pos_d : minor_pos_d;
    pix_x_d = pix_valid_d ? px[CoordBits-1:0] : '0;
    pix_y_d = pix_valid_d ? OutYW'(py) : '0;
  end

  // Control state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q <= 1'b0;
    end else if (s2_fire) begin
      line_active_q <= line_active_d;
    end
  end

  // Advance line state and result register
  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      major_pos_q    <= major_pos_d;
      minor_pos_q    <= minor_pos_d;
      major_end_q    <= major_end_d;
      decision_q     <= decision_d;
      inc_straight_q <= inc_straight_d;
      inc_diagonal_q <= inc_diagonal_d;
      axes_swapped_q <= axes_swapped_d;
      minor_falls_q  <= minor_falls_d;
      pix_x_q        <= pix_x_d;
      pix_y_q        <= pix_y_d;
      pix_valid_q    <= pix_valid_d;
      last_q         <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_valid_o = pix_valid_q;
  assign last_pixel_o  = last_q;

  // Checks
  a_last_ends_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && last_d) |=> !line_active_q)
    else $error("line still active after last pixel");

  a_no_pixel_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pixel_valid_o) |-> (!last_pixel_o && pixel_x_o == '0 && pixel_y_o == '0))
    else $error("empty result carries nonzero fields");

  a_major_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_active_q |-> (major_pos_q < major_end_q))
    else $error("active line has passed its end");

  a_stall_keeps_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("input stage dropped a request under stall");

endmodule : midpoint_line_rasterizer

`default_nettype wire

// File: verif/midpoint_line_checker.sv
`timescale 1ns / 1ps
// Pixel checker for the line rasterizer: tracks line state, predicts each pixel, compares.
module midpoint_line_checker #(
  parameter int unsigned CoordBits = mlr_pkg::CoordBitsDefault
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  input  logic                                    cfg_ready_i,
  input  logic [mlr_pkg::WinHeightBits-1:0]       cfg_data_i,
  input  logic                                    in_valid_i,
  input  logic                                    in_ready_i,
  input  logic                                    req_type_i,
  input  logic [CoordBits-1:0]                    start_x_i,
  input  logic [CoordBits-1:0]                    start_y_i,
  input  logic [CoordBits-1:0]                    end_x_i,
  input  logic [CoordBits-1:0]                    end_y_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_ready_i,
  input  logic [CoordBits-1:0]                    pixel_x_i,
  input  logic signed [CoordBits+1:0]             pixel_y_i,
  input  logic                                    pixel_valid_i,
  input  logic                                    last_pixel_i,
  input  logic                                    end_check_i,
  output int                                      pixels_seen_o,
  output int                                      errors_o
);
  import mlr_pkg::*;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits+1:0] y;
    logic                 valid;
    logic                 last;
  } pixel_t;

  // Line state as the block keeps it
  logic [WinHeightBits-1:0]    win_height;
  logic                        line_on;
  logic                        swapped;
  logic                        falls;
  logic signed [CoordBits+1:0] maj_pos;
  logic signed [CoordBits+1:0] min_pos;
  logic signed [CoordBits+1:0] maj_end;
  logic signed [CoordBits+3:0] decision;
  logic signed [CoordBits+3:0] step_straight;
  logic signed [CoordBits+3:0] step_diag;

  pixel_t pixel_q[$];
  pixel_t want;
  bit     leftover_reported;

  function automatic int abs_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] exp_val,
                             input logic signed [31:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      errors_o++;
    end
  endtask

  // Work out the pixel that one request produces and queue it
  task automatic predict_pixel(input req_type_e kind, input logic [CoordBits-1:0] sx, sy,
                               ex, ey);
    int ax, ay, bx, by, m0, n0, m1, n1, tmp, dmin;
    pixel_t px;
    px = '0;
    if (kind == REQ_START) begin
      // flip y to a bottom-left origin, then pick the major axis
      ax = int'(sx);
      ay = int'(win_height) - int'(sy);
      bx = int'(ex);
      by = int'(win_height) - int'(ey);
      swapped = abs_gap(by, ay) > abs_gap(bx, ax);
      if (swapped) begin
        m0 = ay; n0 = ax; m1 = by; n1 = bx;
      end else begin
        m0 = ax; n0 = ay; m1 = bx; n1 = by;
      end
      // order the endpoints so the major coordinate rises
      if (m0 > m1) begin
        tmp = m0; m0 = m1; m1 = tmp;
        tmp = n0; n0 = n1; n1 = tmp;
      end
      dmin = abs_gap(n1, n0);
      falls = n1 < n0;
      maj_pos = (CoordBits+2)'(m0);
      min_pos = (CoordBits+2)'(n0);
      maj_end = (CoordBits+2)'(m1);
      step_straight = (CoordBits+4)'(2 * dmin);
      step_diag = (CoordBits+4)'(2 * (dmin - (m1 - m0)));
      decision = (CoordBits+4)'(2 * dmin - (m1 - m0));
      line_on = 1'b1;
    end else if (line_on) begin
      // a tie takes the straight step
      if (decision > 0) begin
        min_pos = falls ? (CoordBits+2)'(min_pos - 1) : (CoordBits+2)'(min_pos + 1);
        decision = decision + step_diag;
      end else begin
        decision = decision + step_straight;
      end
      maj_pos = (CoordBits+2)'(maj_pos + 1);
    end
    if (line_on) begin
      px.x = swapped ? min_pos[CoordBits-1:0] : maj_pos[CoordBits-1:0];
      px.y = swapped ? maj_pos : min_pos;
      px.valid = 1'b1;
      px.last = (maj_pos == maj_end);
      if (px.last) line_on = 1'b0;
    end
    pixel_q.push_back(px);
  endtask

  // Watch all three channels; every transfer is handled at the edge it happens on
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_height = WinHeightReset;
      line_on = 1'b0;
      swapped = 1'b0;
      falls = 1'b0;
      maj_pos = '0;
      min_pos = '0;
      maj_end = '0;
      decision = '0;
      step_straight = '0;
      step_diag = '0;
      pixel_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) win_height = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        pixels_seen_o++;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d valid=%0b last=%0b",
                   $time, pixel_x_i, pixel_y_i, pixel_valid_i, last_pixel_i);
          errors_o++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_x", 32'(want.x), 32'(pixel_x_i));
          check_field("pixel_y", 32'($signed(want.y)), 32'(pixel_y_i));
          check_field("pixel_valid", 32'(want.valid), 32'(pixel_valid_i));
          check_field("last_pixel", 32'(want.last), 32'(last_pixel_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_pixel(req_type_e'(req_type_i), start_x_i, start_y_i, end_x_i, end_y_i);
      end
      if (end_check_i && !leftover_reported) begin
        leftover_reported = 1'b1;
        if (pixel_q.size() != 0) begin
          $display("%0t: missing pixels, expected %0d more, got 0", $time, pixel_q.size());
          errors_o++;
        end
      end
    end
  end

endmodule

// File: verif/midpoint_line_rasterizer_test.sv
`timescale 1ns / 1ps
// Testbench top for the line rasterizer: reset, window height phases, line stimulus, verdict.
module midpoint_line_rasterizer_test;
  import mlr_pkg::*;

  localparam int unsigned CoordBits = CoordBitsDefault;
  localparam int CoordMax = (1 << CoordBits) - 1;
  localparam int Latency = 2;
  localparam int CycleLimit = 400000;
  localparam int NumPhases = 6;
  localparam int ItemsPerPhase = 135;
  // idle percentages per phase, cycled: none, sender, receiver, both
  localparam int SendIdle[4] = '{0, 60, 0, 20};
  localparam int RecvStall[4] = '{0, 0, 60, 20};
  // window heights written in phases 1-4; phase 0 keeps the reset value, last is random
  localparam int PhaseHeight[NumPhases] = '{512, 1024, 1, 2047, 0, 512};

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [WinHeightBits-1:0]    cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  req_type_e                   req_type_i = REQ_START;
  logic [CoordBits-1:0]        start_x_i = '0;
  logic [CoordBits-1:0]        start_y_i = '0;
  logic [CoordBits-1:0]        end_x_i = '0;
  logic [CoordBits-1:0]        end_y_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [CoordBits-1:0]        pixel_x_o;
  logic signed [CoordBits+1:0] pixel_y_o;
  logic                        pixel_valid_o;
  logic                        last_pixel_o;
  logic                        end_check = 1'b0;

  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int cycles = 0;
  int pixels_seen;
  int errors;

  midpoint_line_rasterizer #(.CoordBits(CoordBits)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_valid_o (pixel_valid_o),
    .last_pixel_o  (last_pixel_o)
  );

  midpoint_line_checker #(.CoordBits(CoordBits)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .req_type_i    (req_type_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_i     (pixel_x_o),
    .pixel_y_i     (pixel_y_o),
    .pixel_valid_i (pixel_valid_o),
    .last_pixel_i  (last_pixel_o),
    .end_check_i   (end_check),
    .pixels_seen_o (pixels_seen),
    .errors_o      (errors)
  );

  always #5 clk_i = ~clk_i;

  // Stall the pixel channel at the rate of the current phase
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Hold one request on the channel until its transfer, after random idle cycles
  task automatic send_request(input req_type_e kind, input logic [CoordBits-1:0] sx, sy,
                              ex, ey);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    start_x_i <= sx;
    start_y_i <= sy;
    end_x_i <= ex;
    end_y_i <= ey;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
  endtask

  // Send a step whose payload carries random, ignored coordinates
  task automatic send_step();
    send_request(REQ_STEP, CoordBits'($urandom()), CoordBits'($urandom()),
                 CoordBits'($urandom()), CoordBits'($urandom()));
  endtask

  // Start a line and step it
  task automatic draw_line(input int sx, sy, ex, ey, input int steps);
    send_request(REQ_START, CoordBits'(sx), CoordBits'(sy), CoordBits'(ex), CoordBits'(ey));
    repeat (steps) send_step();
  endtask

  // Hold off the sender until every pixel has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixels_seen < requests_sent) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  function automatic int pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return CoordMax;
    return $urandom_range(0, CoordMax);
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > CoordMax) ? CoordMax : v;
  endfunction

  initial begin
    int r, span, x0, y0, x1, y1, major, steps, target;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < NumPhases; phase++) begin
      idle_pct = SendIdle[phase % 4];
      stall_pct = RecvStall[phase % 4];
      if (phase == 0) begin
        // step with nothing active, then a single point and a step past it
        send_step();
        draw_line(5, 5, 5, 5, 1);
        // equal distances on the full diagonal, dropped part way by the next start
        draw_line(0, 0, CoordMax, CoordMax, 3);
        draw_line(CoordMax, 0, 0, CoordMax, 2);
        // steep, horizontal and vertical lines at the coordinate extremes
        draw_line(10, 0, 12, CoordMax, 2);
        draw_line(0, 100, CoordMax, 100, 2);
        draw_line(7, CoordMax, 7, 0, 2);
        // decision tie on the first step, run to the end and one step past
        draw_line(0, 0, 2, 1, 3);
      end else begin
        // reprogram the window height with the pipeline empty
        drain();
        cfg_valid_i <= 1'b1;
        cfg_data_i <= (phase == NumPhases - 1) ? WinHeightBits'($urandom_range(1, 1024))
                                               : WinHeightBits'(PhaseHeight[phase]);
        do @(posedge clk_i); while (!cfg_ready_o);
        cfg_valid_i <= 1'b0;
      end

      // random lines: mostly short and complete, some cut short or overrun
      target = requests_sent + ItemsPerPhase;
      while (requests_sent < target) begin
        r = $urandom_range(99);
        if (r < 5) begin
          repeat ($urandom_range(1, 3)) begin
            send_step();
          end
        end else begin
          r = $urandom_range(99);
          span = (r < 90) ? $urandom_range(0, 12) :
                 (r < 99) ? $urandom_range(13, 64) : $urandom_range(65, 160);
          x0 = pick_coord();
          y0 = pick_coord();
          x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * span)) - span);
          y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * span)) - span);
          major = (x1 > x0) ? x1 - x0 : x0 - x1;
          if (((y1 > y0) ? y1 - y0 : y0 - y1) > major) major = (y1 > y0) ? y1 - y0 : y0 - y1;
          r = $urandom_range(99);
          steps = (r < 75) ? major :
                  (r < 88) ? major + int'($urandom_range(1, 3)) : $urandom_range(0, major);
          draw_line(x0, y0, x1, y1, steps);
        end
      end
    end

    // let the last pixels through, then flag anything still owed
    drain();
    end_check <= 1'b1;
    repeat (3) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mlr_pkg.sv
hw/rtl/midpoint_line_rasterizer.sv
verif/midpoint_line_checker.sv
verif/midpoint_line_rasterizer_test.sv
